// ===== design/bfds_pkg.sv =====
// Shared types and constants for the brute-force discord search block.
package bfds_pkg;

    // Width of a squared distance; all ones means "no neighbour".
    localparam int DIST_W = 41;
    localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};

    // Width of the configuration register and its reset value.
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] SUBSEQ_LEN_RESET = 7'd16;

    // Cycles from the last issued read to the final best-so-far update.
    localparam int DRAIN_CYCLES = 6;
    localparam int DRAIN_W = $clog2(DRAIN_CYCLES + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // One beat of the comparison pipeline.
    typedef struct packed {
        logic valid;
        logic use_pair;
        logic first_k;
        logic last_k;
        logic row_last;
        logic row_first;
    } beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  wr_en;
        logic  clear;
        logic  set_short;
        beat_t beat;
    } dp_cmd_t;

endpackage

// ===== design/bfds_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module bfds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= mem_reg[raddr_a];
        rd_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ===== design/bfds_dp.sv =====
// Datapath: sample store, squared-distance pipeline, row minimum and running maximum.
module bfds_dp
    import bfds_pkg::*;
#(
    parameter int MAX_SERIES_LEN = 1024,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dp_cmd_t                           cmd,
    input  logic [$clog2(MAX_SERIES_LEN)-1:0] waddr,
    input  logic [SAMPLE_BITS-1:0]            wdata,
    input  logic [$clog2(MAX_SERIES_LEN)-1:0] raddr_a,
    input  logic [$clog2(MAX_SERIES_LEN)-1:0] raddr_b,
    input  logic [$clog2(MAX_SERIES_LEN)-1:0] row_idx,
    output logic [$clog2(MAX_SERIES_LEN)-1:0] discord_start,
    output logic [DIST_W-1:0]                 nn_distance,
    output logic                              no_neighbour,
    output logic                              too_short
);

    localparam int ADDR_W = $clog2(MAX_SERIES_LEN);
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ACC_W  = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
    localparam logic [ACC_W-1:0] ACC_NONE = ACC_W'(DIST_NONE);

    logic [SAMPLE_BITS-1:0] rd_a;
    logic [SAMPLE_BITS-1:0] rd_b;

    bfds_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SERIES_LEN)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Stage flags and row tags
    beat_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic [ADDR_W-1:0] s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg;

    logic [DIFF_W-1:0] adiff_reg, adiff_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [DIST_W-1:0] sum_reg, sum_next;
    logic [DIST_W-1:0] rowmin_reg, rowmin_next;
    logic [DIST_W-1:0] rowfin_reg;
    logic              rowfin_valid_reg;
    logic              rowfin_first_reg;
    logic [ADDR_W-1:0] rowfin_row_reg;
    logic [DIST_W-1:0] best_reg;
    logic [ADDR_W-1:0] start_reg;
    logic              any_reg;
    logic              short_reg;

    logic signed [DIFF_W-1:0] diff;
    logic [ACC_W-1:0]         acc_wide;
    logic [DIST_W-1:0]        row_cand;

    always_comb
    begin
        diff = $signed({rd_a[SAMPLE_BITS-1], rd_a}) - $signed({rd_b[SAMPLE_BITS-1], rd_b});
        adiff_next = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        sq_next = SQ_W'(adiff_reg) * SQ_W'(adiff_reg);

        // accumulate with saturation just below the no-neighbour code
        if (s3_reg.first_k)
        begin
            acc_wide = ACC_W'(sq_reg);
        end
        else
        begin
            acc_wide = ACC_W'(sum_reg) + ACC_W'(sq_reg);
        end
        if (acc_wide >= ACC_NONE)
        begin
            sum_next = DIST_NONE - DIST_W'(1);
        end
        else
        begin
            sum_next = acc_wide[DIST_W-1:0];
        end

        if (s4_reg.valid && s4_reg.use_pair && s4_reg.last_k && (sum_reg < rowmin_reg))
        begin
            row_cand = sum_reg;
        end
        else
        begin
            row_cand = rowmin_reg;
        end
        rowmin_next = (s4_reg.valid && s4_reg.row_last) ? DIST_NONE : row_cand;
    end

    // Pipeline flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            rowfin_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= cmd.beat;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            rowfin_valid_reg <= s4_reg.valid && s4_reg.row_last;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        s1_row_reg <= row_idx;
        s2_row_reg <= s1_row_reg;
        s3_row_reg <= s2_row_reg;
        s4_row_reg <= s3_row_reg;
        adiff_reg  <= adiff_next;
        sq_reg     <= sq_next;
        if (s3_reg.valid && s3_reg.use_pair)
        begin
            sum_reg <= sum_next;
        end
        rowfin_reg       <= row_cand;
        rowfin_first_reg <= s4_reg.row_first;
        rowfin_row_reg   <= s4_row_reg;
    end

    // Row minimum, running maximum and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rowmin_reg <= DIST_NONE;
            best_reg   <= '0;
            start_reg  <= '0;
            any_reg    <= 1'b0;
            short_reg  <= 1'b0;
        end
        else if (cmd.clear || cmd.set_short)
        begin
            rowmin_reg <= DIST_NONE;
            best_reg   <= '0;
            start_reg  <= '0;
            any_reg    <= 1'b0;
            short_reg  <= cmd.set_short;
        end
        else
        begin
            rowmin_reg <= rowmin_next;
            if (s4_reg.valid && s4_reg.use_pair)
            begin
                any_reg <= 1'b1;
            end
            if (rowfin_valid_reg && (rowfin_first_reg || (rowfin_reg > best_reg)))
            begin
                best_reg  <= rowfin_reg;
                start_reg <= rowfin_row_reg;
            end
        end
    end

    assign discord_start = start_reg;
    assign nn_distance   = best_reg;
    assign no_neighbour  = !any_reg && !short_reg;
    assign too_short     = short_reg;

endmodule

// ===== design/bfds_ctrl.sv =====
// Controller: sample loading, search loop sequencing and result handshake.
module bfds_ctrl
    import bfds_pkg::*;
#(
    parameter int MAX_SERIES_LEN = 1024,
    parameter int MAX_SUBSEQ_LEN = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [CFG_W-1:0]                  cfg_wr_data,
    input  logic                              in_valid,
    input  logic                              last,
    output logic                              in_stall,
    output logic                              out_valid,
    input  logic                              out_stall,
    output dp_cmd_t                           cmd,
    output logic [$clog2(MAX_SERIES_LEN)-1:0] waddr,
    output logic [$clog2(MAX_SERIES_LEN)-1:0] raddr_a,
    output logic [$clog2(MAX_SERIES_LEN)-1:0] raddr_b,
    output logic [$clog2(MAX_SERIES_LEN)-1:0] row_idx
);

    localparam int ADDR_W = $clog2(MAX_SERIES_LEN);
    localparam int CNT_W  = $clog2(MAX_SERIES_LEN + 1);
    localparam int LEN_W  = $clog2(MAX_SUBSEQ_LEN + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CFG_W-1:0]   len_reg;
    logic [LEN_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   rows_reg, rows_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [LEN_W-1:0]   k_reg, k_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;

    logic        in_acc;
    logic        out_acc;
    logic [31:0] eff_wide;
    logic [31:0] m_wide;
    logic [31:0] i_w, j_w, k_w, n_w, rows_w;
    logic        neighbour;
    logic        k_end;
    logic        j_end;
    logic        i_end;
    logic        pair_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= SUBSEQ_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            n_reg     <= '0;
            rows_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            rows_reg  <= rows_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        // clamp length: zero acts as one, large values as the maximum
        if (len_reg == '0)
        begin
            eff_wide = 32'd1;
        end
        else if (32'(len_reg) > 32'(MAX_SUBSEQ_LEN))
        begin
            eff_wide = 32'(MAX_SUBSEQ_LEN);
        end
        else
        begin
            eff_wide = 32'(len_reg);
        end

        i_w    = 32'(i_reg);
        j_w    = 32'(j_reg);
        k_w    = 32'(k_reg);
        n_w    = 32'(n_reg);
        rows_w = 32'(rows_reg);

        neighbour = ((j_w + n_w) <= i_w) || (j_w >= (i_w + n_w));
        k_end     = (k_w == (n_w - 32'd1));
        j_end     = (j_w == (rows_w - 32'd1));
        i_end     = (i_w == (rows_w - 32'd1));
        pair_done = !neighbour || k_end;

        in_stall  = (state_reg == ST_SEARCH) || (state_reg == ST_DRAIN)
                    || ((state_reg == ST_OUT) && last);
        out_valid = (state_reg == ST_OUT);
        in_acc    = in_valid && !in_stall;
        out_acc   = out_valid && !out_stall;

        // count after this sample, saturating when the store is full
        if (32'(count_reg) < 32'(MAX_SERIES_LEN))
        begin
            m_wide = 32'(count_reg) + 32'd1;
        end
        else
        begin
            m_wide = 32'(count_reg);
        end

        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        rows_next  = rows_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        drain_next = drain_reg;

        cmd        = '0;
        waddr      = count_reg[ADDR_W-1:0];
        raddr_a    = ADDR_W'(i_w + k_w);
        raddr_b    = ADDR_W'(j_w + k_w);
        row_idx    = i_reg;

        unique case (state_reg)
            ST_LOAD, ST_OUT:
            begin
                if (out_acc)
                begin
                    state_next = ST_LOAD;
                end
                if (in_acc)
                begin
                    cmd.wr_en  = (32'(count_reg) < 32'(MAX_SERIES_LEN));
                    count_next = CNT_W'(m_wide);
                    if (last)
                    begin
                        count_next = '0;
                        n_next     = LEN_W'(eff_wide);
                        rows_next  = CNT_W'(m_wide - eff_wide + 32'd1);
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        if (m_wide < eff_wide)
                        begin
                            cmd.set_short = 1'b1;
                            state_next    = ST_OUT;
                        end
                        else
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.beat.valid     = 1'b1;
                cmd.beat.use_pair  = neighbour;
                cmd.beat.first_k   = (k_reg == '0);
                cmd.beat.last_k    = pair_done;
                cmd.beat.row_last  = pair_done && j_end;
                cmd.beat.row_first = (i_reg == '0);
                if (pair_done)
                begin
                    k_next = '0;
                    if (j_end)
                    begin
                        j_next = '0;
                        if (i_end)
                        begin
                            drain_next = '0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + ADDR_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + LEN_W'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + DRAIN_W'(1);
                if (32'(drain_reg) == 32'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== design/brute_force_discord_search.sv =====
// Top level of the brute-force time series discord search.
//
// Samples stream in one per cycle while in_stall is low (one transaction
// each) and are written to an on-chip sample store; the transaction with last
// high closes the series and starts the search. Every subsequence of length n
// (subseq_len, with 0 taken as 1 and values above MAX_SUBSEQ_LEN taken as
// MAX_SUBSEQ_LEN) is compared with every subsequence starting at least n away,
// using the exact squared Euclidean distance; the subsequence whose
// nearest-neighbour distance is largest is reported, ties to the lowest start.
// Samples past MAX_SERIES_LEN are dropped. With m samples and R = m - n + 1
// rows, the search visits every (row, column) pair: an overlapping pair is
// skipped, one that does not overlap steps through its n samples. Its speed is
// set by the single pair of read ports on the sample store feeding one squaring
// unit, and it ends with a pipeline drain. The result is then held on the
// output until taken; samples of the next series are accepted meanwhile, but
// its closing sample is stalled until the result transaction completes. A
// series shorter than n reports too_short in the cycle right after its closing
// sample is taken. subseq_len is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle, which the block does not enforce.
module brute_force_discord_search
    import bfds_pkg::*;
#(
    parameter int MAX_SERIES_LEN = 1024,
    parameter int MAX_SUBSEQ_LEN = 64,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [CFG_W-1:0]                  cfg_wr_data,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic                              last,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [$clog2(MAX_SERIES_LEN)-1:0] discord_start,
    output logic [DIST_W-1:0]                 nn_distance,
    output logic                              no_neighbour,
    output logic                              too_short
);

    localparam int ADDR_W = $clog2(MAX_SERIES_LEN);

    dp_cmd_t           cmd;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [ADDR_W-1:0] row_idx;

    // Sequencer: load counter, i/j/k loop counters, handshake
    bfds_ctrl #(
        .MAX_SERIES_LEN (MAX_SERIES_LEN),
        .MAX_SUBSEQ_LEN (MAX_SUBSEQ_LEN)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .last        (last),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .waddr       (waddr),
        .raddr_a     (raddr_a),
        .raddr_b     (raddr_b),
        .row_idx     (row_idx)
    );

    // Store, distance pipeline and result registers
    bfds_dp #(
        .MAX_SERIES_LEN (MAX_SERIES_LEN),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .waddr         (waddr),
        .wdata         (sample),
        .raddr_a       (raddr_a),
        .raddr_b       (raddr_b),
        .row_idx       (row_idx),
        .discord_start (discord_start),
        .nn_distance   (nn_distance),
        .no_neighbour  (no_neighbour),
        .too_short     (too_short)
    );

endmodule

// ===== test/tb_brute_force_discord_search.sv =====
// Self-checking testbench for the brute-force time series discord search block.
`timescale 1ns / 1ps

module tb_brute_force_discord_search
    import bfds_pkg::*;
();

    localparam int MAX_SERIES = 1024;
    localparam int MAX_SUBSEQ = 64;
    localparam int RANDOM_ITEMS = 1200;

    // One expected search outcome, field for field as on the result port.
    typedef struct packed {
        logic [9:0]        start_idx;
        logic [DIST_W-1:0] nn_dist;
        logic              no_nb;
        logic              is_short;
    } discord_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CFG_W-1:0]   cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        sample;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic [9:0]         discord_start;
    logic [DIST_W-1:0]  nn_distance;
    logic               no_neighbour;
    logic               too_short;

    // Shadow copy of the block's series store and length register.
    logic signed [15:0] series_mem [MAX_SERIES];
    int                 series_count;
    logic [CFG_W-1:0]   cur_len;

    discord_t           expected_discords [$];
    discord_t           head_discord;
    logic [15:0]        series_buf [$];
    int                 mismatch_count;
    bit                 in_idle_on;
    bit                 out_idle_on;

    brute_force_discord_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .discord_start (discord_start),
        .nn_distance   (nn_distance),
        .no_neighbour  (no_neighbour),
        .too_short     (too_short)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int clamp_len(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SUBSEQ)
            return MAX_SUBSEQ;
        return int'(v);
    endfunction

    // Squared Euclidean distance, saturating just below the no-neighbour code.
    function automatic logic [DIST_W-1:0] pair_dist(int a, int b, int n);
        logic [63:0] acc;
        longint      diff;
        int          k;
        acc = '0;
        for (k = 0; k < n; k++)
        begin
            diff = longint'(series_mem[a + k]) - longint'(series_mem[b + k]);
            if (diff < 0)
                diff = -diff;
            acc += 64'(diff * diff);
            if (acc >= 64'(DIST_NONE))
                acc = 64'(DIST_NONE) - 64'd1;
        end
        return acc[DIST_W-1:0];
    endfunction

    function automatic discord_t predict_discord(int m, int n);
        discord_t          r;
        logic [DIST_W-1:0] row_min;
        logic [DIST_W-1:0] d;
        int                rows;
        int                i;
        int                j;
        bit                any_nb;
        r = '0;
        any_nb = 1'b0;
        if (m < n)
        begin
            r.is_short = 1'b1;
            return r;
        end
        rows = m - n + 1;
        for (i = 0; i < rows; i++)
        begin
            row_min = DIST_NONE;
            for (j = 0; j < rows; j++)
            begin
                // only neighbours outside the self-match zone count
                if (j + n <= i || j >= i + n)
                begin
                    d = pair_dist(i, j, n);
                    any_nb = 1'b1;
                    if (d < row_min)
                        row_min = d;
                end
            end
            // ties keep the earlier start
            if (i == 0 || row_min > r.nn_dist)
            begin
                r.nn_dist = row_min;
                r.start_idx = 10'(i);
            end
        end
        r.no_nb = !any_nb;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One sample transaction. follow tells whether another sample may be
    // driven at the very edge of acceptance; otherwise valid drops first.
    task automatic send_sample(input logic [15:0] value, input logic closing,
                               input bit follow);
        int gap;
        in_valid <= 1'b1;
        sample   <= value;
        last     <= closing;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (series_count < MAX_SERIES)
        begin
            series_mem[series_count] = value;
            series_count++;
        end
        if (closing)
        begin
            expected_discords.push_back(predict_discord(series_count, clamp_len(cur_len)));
            series_count = 0;
        end
        gap = pick_gap(in_idle_on);
        if (gap > 0 || !follow)
        begin
            in_valid <= 1'b0;
            repeat (gap > 0 ? gap : 1) @(posedge clk);
        end
    endtask

    // Sends series_buf as one series, closing on its final sample.
    task automatic send_series(input bit more_after);
        int idx;
        int cnt;
        cnt = series_buf.size();
        for (idx = 0; idx < cnt; idx++)
            send_sample(series_buf[idx], idx == cnt - 1, more_after || idx != cnt - 1);
        series_buf.delete();
    endtask

    // Length register is only touched with nothing in flight.
    task automatic set_length(input logic [CFG_W-1:0] value);
        @(posedge clk);
        while (expected_discords.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES + 4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_len = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset length of 16 with ten samples: too short.
    task automatic test_reset_length();
        int k;
        for (k = 0; k < 10; k++)
            series_buf.push_back(k[0] ? 16'h8000 : 16'h7FFF);
        send_series(1'b0);
    endtask

    // Zero acts as one; full-scale swings give the largest distances.
    task automatic test_zero_length();
        set_length(7'd0);
        series_buf.push_back(16'h7FFF);
        series_buf.push_back(16'h8000);
        series_buf.push_back(16'h7FFF);
        series_buf.push_back(16'h0000);
        send_series(1'b0);
    endtask

    // Length one: a lone sample has no neighbour, a pair does.
    task automatic test_single_sample();
        set_length(7'd1);
        series_buf.push_back(16'h1234);
        send_series(1'b1);
        series_buf.push_back(16'hFFFF);
        series_buf.push_back(16'h0001);
        send_series(1'b0);
    endtask

    task automatic test_too_short();
        set_length(7'd5);
        repeat (4) series_buf.push_back(16'($urandom));
        send_series(1'b0);
    endtask

    // Fewer than 2n samples: nobody has a neighbour.
    task automatic test_no_neighbour();
        set_length(7'd3);
        repeat (5) series_buf.push_back(16'($urandom));
        send_series(1'b0);
    endtask

    // n = 3, m = 7: the middle row has no neighbour and wins with all ones.
    task automatic test_partial_rows();
        set_length(7'd3);
        repeat (7) series_buf.push_back(16'($urandom));
        send_series(1'b0);
    endtask

    // Planted anomaly at the very start of the series.
    task automatic test_discord_at_zero();
        set_length(7'd2);
        series_buf.push_back(16'd20000);
        series_buf.push_back(-16'sd20000);
        repeat (6) series_buf.push_back(16'h0000);
        send_series(1'b0);
    endtask

    // Flat series: every distance is zero, first row must win.
    task automatic test_ties();
        set_length(7'd2);
        repeat (6) series_buf.push_back(16'd5);
        send_series(1'b0);
    endtask

    // 127 acts as 64: 70 samples is long enough, but without neighbours.
    task automatic test_length_clamp();
        set_length(7'd127);
        repeat (70) series_buf.push_back(16'($urandom));
        send_series(1'b0);
    endtask

    // Overfill the store; excess samples drop, the closing one still ends it.
    task automatic test_store_full();
        set_length(7'd1);
        repeat (MAX_SERIES + 6) series_buf.push_back(16'($urandom));
        send_series(1'b0);
    endtask

    // Phases of random length settings, each with a run of back-to-back series.
    task automatic test_random_series();
        int               sent;
        int               nseries;
        int               s;
        int               n;
        int               m;
        int               k;
        int               style;
        int               period;
        int               spike;
        int               r;
        logic [CFG_W-1:0] len_cfg;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                len_cfg = 7'd0;
            else if (r == 1)
                len_cfg = 7'd64;
            else if (r == 2)
                len_cfg = 7'($urandom_range(65, 127));
            else if (r < 6)
                len_cfg = 7'($urandom_range(1, 4));
            else
                len_cfg = 7'($urandom_range(5, 8));
            set_length(len_cfg);
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            n = clamp_len(len_cfg);
            nseries = $urandom_range(3, 8);
            for (s = 0; s < nseries; s++)
            begin
                // mostly series long enough to have neighbours, unless n is at its maximum
                if (n >= MAX_SUBSEQ)
                    m = $urandom_range(60, 140);
                else if ($urandom_range(0, 99) < 80)
                    m = $urandom_range(2 * n, 2 * n + 32);
                else
                    m = $urandom_range(1, 2 * n - 1 > 1 ? 2 * n - 1 : 1);
                style  = $urandom_range(0, 3);
                period = $urandom_range(2, 6);
                spike  = $urandom_range(0, m - 1);
                for (k = 0; k < m; k++)
                begin
                    case (style)
                        0: series_buf.push_back(16'($urandom));
                        1: series_buf.push_back(16'($urandom_range(0, 6) - 3));
                        2: series_buf.push_back($urandom_range(0, 1) ?
                               ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000) :
                               ($urandom_range(0, 1) ? 16'h0000 : 16'hFFFF));
                        default: series_buf.push_back(k == spike ? 16'($urandom) :
                               16'((k % period) * 3000 - 6000));
                    endcase
                end
                send_series(s != nseries - 1);
                sent += m;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("discord mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Each result transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_discords.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: start %0d distance %0d",
                             discord_start, nn_distance);
            end
            else
            begin
                head_discord = expected_discords.pop_front();
                check_field("discord_start", 64'(head_discord.start_idx), 64'(discord_start));
                check_field("nn_distance", 64'(head_discord.nn_dist), 64'(nn_distance));
                check_field("no_neighbour", 64'(head_discord.no_nb), 64'(no_neighbour));
                check_field("too_short", 64'(head_discord.is_short), 64'(too_short));
            end
        end
    end

    // Receiver back-pressure: stall bursts of random length between ready runs.
    initial
    begin
        int len;
        out_stall <= 1'b0;
        forever
        begin
            len = pick_gap(out_idle_on);
            @(posedge clk);
            if (len > 0)
            begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        sample      <= '0;
        last        <= 1'b0;
        mismatch_count = 0;
        series_count   = 0;
        cur_len        = SUBSEQ_LEN_RESET;
        in_idle_on     = 1'b1;
        out_idle_on    = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_length();
        test_zero_length();
        test_single_sample();
        test_too_short();
        test_no_neighbour();
        test_partial_rows();
        test_discord_at_zero();
        test_ties();
        test_length_clamp();
        test_store_full();
        test_random_series();

        while (expected_discords.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial
    begin
        #80_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
